FILE: hw/rtl/mpcc_pkg.sv
package mpcc_pkg;

    // APB register map: register i at byte address 4*i
    localparam int AddrWidth = 5;
    localparam int DataWidth = 32;
    localparam int RegIdxWidth = 3;

    localparam logic [RegIdxWidth-1:0] REG_DEAD_TICKS        = 3'd0;
    localparam logic [RegIdxWidth-1:0] REG_IDLE_RESET_TICKS  = 3'd1;
    localparam logic [RegIdxWidth-1:0] REG_CLICK_MIN_TICKS   = 3'd2;
    localparam logic [RegIdxWidth-1:0] REG_CLICK_MAX_TICKS   = 3'd3;
    localparam logic [RegIdxWidth-1:0] REG_CLICK_ENABLE_MASK = 3'd4;

    // Field widths of the registers and the result
    localparam int DeadWidth = 8;
    localparam int CfgTickWidth = 16;
    localparam int MaskWidth = 5;
    localparam int CountWidth = 3;

    // Event codes
    localparam logic EVENT_DETECT_START = 1'b0;
    localparam logic EVENT_BURST_END    = 1'b1;

    typedef struct packed {
        logic [DeadWidth-1:0]    dead_ticks;
        logic [CfgTickWidth-1:0] idle_reset_ticks;
        logic [CfgTickWidth-1:0] click_min_ticks;
        logic [CfgTickWidth-1:0] click_max_ticks;
        logic [MaskWidth-1:0]    click_enable_mask;
    } mpcc_cfg_t;

    localparam mpcc_cfg_t CfgReset = '{
        dead_ticks:        8'd5,
        idle_reset_ticks:  16'd50,
        click_min_ticks:   16'd10,
        click_max_ticks:   16'd25,
        click_enable_mask: 5'd31
    };

    typedef struct packed {
        logic                  event_kind;
        logic [CountWidth-1:0] click_count;
        logic                  click_action;
    } mpcc_result_t;

endpackage

FILE: hw/rtl/mpcc_cfg.sv
module mpcc_cfg
    import mpcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [DataWidth-1:0] pwdata,
    output logic [DataWidth-1:0] prdata,
    output mpcc_cfg_t            cfg
);

    mpcc_cfg_t              cfg_reg;
    logic [RegIdxWidth-1:0] reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[AddrWidth-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CfgReset;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEAD_TICKS:        cfg_reg.dead_ticks        <= pwdata[DeadWidth-1:0];
                REG_IDLE_RESET_TICKS:  cfg_reg.idle_reset_ticks  <= pwdata[CfgTickWidth-1:0];
                REG_CLICK_MIN_TICKS:   cfg_reg.click_min_ticks   <= pwdata[CfgTickWidth-1:0];
                REG_CLICK_MAX_TICKS:   cfg_reg.click_max_ticks   <= pwdata[CfgTickWidth-1:0];
                REG_CLICK_ENABLE_MASK: cfg_reg.click_enable_mask <= pwdata[MaskWidth-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DEAD_TICKS:        prdata = DataWidth'(cfg_reg.dead_ticks);
            REG_IDLE_RESET_TICKS:  prdata = DataWidth'(cfg_reg.idle_reset_ticks);
            REG_CLICK_MIN_TICKS:   prdata = DataWidth'(cfg_reg.click_min_ticks);
            REG_CLICK_MAX_TICKS:   prdata = DataWidth'(cfg_reg.click_max_ticks);
            REG_CLICK_ENABLE_MASK: prdata = DataWidth'(cfg_reg.click_enable_mask);
            default:               prdata = '0;
        endcase
    end

endmodule

FILE: hw/rtl/mpcc_core.sv
module mpcc_core
    import mpcc_pkg::*;
#(
    parameter int PULSE_SLOTS = 5,
    parameter int TICK_WIDTH  = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  mpcc_cfg_t    cfg,
    input  logic         take,
    input  logic         sensor_level,
    output logic         res_valid,
    output mpcc_result_t res
);

    localparam int IdxWidth = (PULSE_SLOTS > 1) ? $clog2(PULSE_SLOTS) : 1;
    localparam int HitWidth = $clog2(PULSE_SLOTS + 1);
    localparam int CmpWidth = (TICK_WIDTH > CfgTickWidth) ? TICK_WIDTH : CfgTickWidth;
    localparam int WideCnt  = HitWidth + CountWidth;

    logic                                  last_level_reg, last_level_next;
    logic [TICK_WIDTH-1:0]                 detect_ticks_reg, detect_ticks_next;
    logic [TICK_WIDTH-1:0]                 idle_ticks_reg, idle_ticks_next;
    logic [PULSE_SLOTS-1:0][TICK_WIDTH-1:0] pulse_store_reg, pulse_store_next;
    logic [IdxWidth-1:0]                   write_index_reg, write_index_next;

    logic [PULSE_SLOTS-1:0][TICK_WIDTH-1:0] store_upd;
    logic [PULSE_SLOTS-1:0]                hits;
    logic [WideCnt-1:0]                    count_wide;
    logic [TICK_WIDTH-1:0]                 detect_inc;
    logic [TICK_WIDTH-1:0]                 idle_inc;
    logic                                  in_dead;
    logic                                  burst;

    // saturating tick counters
    assign detect_inc = (detect_ticks_reg == '1) ? detect_ticks_reg : detect_ticks_reg + 1'b1;
    assign idle_inc   = (idle_ticks_reg == '1) ? idle_ticks_reg : idle_ticks_reg + 1'b1;

    // input is ignored during the dead time after a detection start
    assign in_dead = !last_level_reg &&
                     (CmpWidth'(detect_ticks_reg) < CmpWidth'(cfg.dead_ticks));

    // per-tick state update and event generation
    always_comb
    begin
        last_level_next  = last_level_reg;
        detect_ticks_next = detect_ticks_reg;
        idle_ticks_next  = idle_ticks_reg;
        write_index_next = write_index_reg;
        store_upd        = pulse_store_reg;
        pulse_store_next = pulse_store_reg;
        hits             = '0;
        count_wide       = '0;
        burst            = 1'b0;
        res_valid        = 1'b0;
        res              = '0;

        if (take)
        begin
            if (in_dead)
            begin
                detect_ticks_next = detect_inc;
            end
            else
            begin
                last_level_next = sensor_level;
                if (!sensor_level)
                begin
                    // motion active: report the leading edge
                    if (detect_ticks_reg == '0)
                    begin
                        res_valid        = 1'b1;
                        res.event_kind   = EVENT_DETECT_START;
                    end
                    detect_ticks_next = detect_inc;
                    idle_ticks_next   = '0;
                end
                else
                begin
                    // release: log the pulse length into the ring
                    if (detect_ticks_reg != '0)
                    begin
                        store_upd[write_index_reg] = detect_ticks_reg;
                        if (write_index_reg == IdxWidth'(PULSE_SLOTS - 1))
                            write_index_next = '0;
                        else
                            write_index_next = write_index_reg + 1'b1;
                    end
                    idle_ticks_next   = idle_inc;
                    detect_ticks_next = '0;
                end

                // burst end check on the updated ring
                for (int i = 0; i < PULSE_SLOTS; i++)
                begin
                    hits[i] = (CmpWidth'(store_upd[i]) >= CmpWidth'(cfg.click_min_ticks)) &&
                              (CmpWidth'(store_upd[i]) <= CmpWidth'(cfg.click_max_ticks));
                end
                count_wide = WideCnt'($countones(hits));
                burst = (CmpWidth'(idle_ticks_next) > CmpWidth'(cfg.idle_reset_ticks)) &&
                        (store_upd[0] != '0);

                pulse_store_next = store_upd;
                if (burst)
                begin
                    res_valid        = 1'b1;
                    res.event_kind   = EVENT_BURST_END;
                    res.click_count  = count_wide[CountWidth-1:0];
                    if ((count_wide >= WideCnt'(1)) && (count_wide <= WideCnt'(MaskWidth)))
                        res.click_action =
                            cfg.click_enable_mask[CountWidth'(count_wide - WideCnt'(1))];
                    pulse_store_next = '0;
                    write_index_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg   <= 1'b1;
            detect_ticks_reg <= '0;
            idle_ticks_reg   <= '0;
            pulse_store_reg  <= '0;
            write_index_reg  <= '0;
        end
        else
        begin
            last_level_reg   <= last_level_next;
            detect_ticks_reg <= detect_ticks_next;
            idle_ticks_reg   <= idle_ticks_next;
            pulse_store_reg  <= pulse_store_next;
            write_index_reg  <= write_index_next;
        end
    end

endmodule

FILE: hw/rtl/mpcc_out.sv
module mpcc_out
    import mpcc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  mpcc_result_t res,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output mpcc_result_t out_res
);

    logic         valid_reg;
    mpcc_result_t res_reg;

    // a slot is free when empty or being drained this cycle
    assign space     = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (space && push)
        begin
            res_reg <= res;
        end
    end

endmodule

FILE: hw/rtl/motion_pulse_click_counter.sv
// Motion pulse click counter. Each accepted item is one poll tick of the
// active-low motion line. The block takes one item per clock cycle while
// sensor_ready is high, which drops only while a finished event sits unread
// and event_ready is low; all per-tick counters, the pulse ring and the five
// window compares settle combinationally, and the event (detection start, or
// burst end with click count and action flag) appears in the output register
// in the cycle after the tick is taken. Registers sit on the APB port at byte
// addresses 0x00 dead_ticks, 0x04 idle_reset_ticks, 0x08 click_min_ticks,
// 0x0C click_max_ticks, 0x10 click_enable_mask; write them only while idle.
module motion_pulse_click_counter
    import mpcc_pkg::*;
#(
    parameter int PULSE_SLOTS = 5,
    parameter int TICK_WIDTH  = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [AddrWidth-1:0]  paddr,
    input  logic [DataWidth-1:0]  pwdata,
    output logic [DataWidth-1:0]  prdata,
    output logic                  pready,
    input  logic                  sensor_valid,
    output logic                  sensor_ready,
    input  logic                  sensor_level,
    output logic                  event_valid,
    input  logic                  event_ready,
    output logic                  event_kind,
    output logic [CountWidth-1:0] click_count,
    output logic                  click_action
);

    mpcc_cfg_t    cfg;
    mpcc_result_t res;
    mpcc_result_t out_res;
    logic         res_valid;
    logic         space;
    logic         take;

    assign pready       = 1'b1;
    assign sensor_ready = space;
    assign take         = sensor_valid && space;

    mpcc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    mpcc_core #(
        .PULSE_SLOTS (PULSE_SLOTS),
        .TICK_WIDTH  (TICK_WIDTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .take         (take),
        .sensor_level (sensor_level),
        .res_valid    (res_valid),
        .res          (res)
    );

    mpcc_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take && res_valid),
        .res       (res),
        .space     (space),
        .out_valid (event_valid),
        .out_ready (event_ready),
        .out_res   (out_res)
    );

    assign event_kind   = out_res.event_kind;
    assign click_count  = out_res.click_count;
    assign click_action = out_res.click_action;

endmodule
